// File: rtl/core/gela_pkg.sv
// Package: shared constants, codes, state type and index helpers of the log-likelihood accumulator.
`timescale 1ns / 1ps
package gela_pkg;

  localparam int MAX_LOCI    = 256;
  localparam int TABLE_COLS  = 32;
  localparam int MAX_ALLELES = 64;

  localparam int LOCUS_W  = $clog2(MAX_LOCI);
  localparam int COL_W    = $clog2(TABLE_COLS);
  localparam int ALLELE_W = $clog2(MAX_ALLELES);
  localparam int FREQ_W   = 16;
  localparam int TERM_W   = 32;
  localparam int SUM_W    = 40;

  localparam int ERR_DEPTH = MAX_LOCI * TABLE_COLS;
  localparam int FRQ_DEPTH = MAX_LOCI * MAX_ALLELES;

  localparam logic [1:0] MODE_ERR   = 2'd0;
  localparam logic [1:0] MODE_FREQ  = 2'd1;
  localparam logic [1:0] MODE_SCORE = 2'd2;

  localparam logic [1:0] MODEL_MIX   = 2'd0;
  localparam logic [1:0] MODEL_SNP   = 2'd1;
  localparam logic [1:0] MODEL_CLASS = 2'd2;

  localparam logic [23:0] LN2_Q24   = 24'd11629080;
  localparam logic [28:0] EXP_LIMIT = 29'd383759640;
  localparam logic signed [31:0] LN_FLOOR = 32'sh8000_0000;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [3:0]  TAY_LAST = 4'd12;

  localparam logic signed [40:0] SUM_MAX = 41'sh0_7F_FFFF_FFFF;
  localparam logic signed [40:0] SUM_MIN = 41'sh1_80_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_MULP, S_PROD,
    S_LN_NORM, S_LN_SQ, S_LN_CHK, S_LN_MUL, S_LN_END,
    S_LSE, S_EXP_RED, S_TAY_MUL, S_TAY_LD, S_TAY_DIV, S_TAY_ADD, S_EXP_END,
    S_RD_E, S_GET_E, S_ACC, S_EMIT
  } gela_state_e;

  function automatic logic [8:0] snp_col(input logic [5:0] o1, input logic [5:0] a1,
                                         input logic [1:0] c);
    logic [8:0] o;
    o = {3'b0, o1};
    return (o << 1) + o + {3'b0, a1} + {5'b0, c, 2'b0} + {6'b0, c, 1'b0};
  endfunction

  function automatic logic [4:0] class_col(input logic [5:0] o1, input logic [5:0] o2,
                                           input logic [5:0] a1, input logic [5:0] a2,
                                           input logic [1:0] c);
    logic [2:0] k;
    k = 3'd0;
    if (o1 == o2) begin
      k = 3'd1;
      if (a1 == o1 && a2 == o1) k = 3'd0;
      if (a1 != o1 && a2 != o1) k = 3'd2;
    end else begin
      k = 3'd5;
      if (a1 == a2) k = 3'd4;
      if ((a1 == o1 && a2 == o2) || (a1 == o2 && a2 == o1)) k = 3'd3;
      if (a1 != o1 && a2 != o2 && a1 != o2 && a2 != o1) k = 3'd6;
    end
    return {2'b0, k} + {c, 3'b0} - {3'b0, c};
  endfunction

endpackage

// File: rtl/core/gela_in_if.sv
// Interface: input item channel of the log-likelihood accumulator.
`timescale 1ns / 1ps
interface gela_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [gela_pkg::LOCUS_W-1:0]        locus;
  logic [5:0]                          entry_index;
  logic signed [gela_pkg::TERM_W-1:0]  table_value;
  logic [1:0]                          category;
  logic [5:0]                          obs_first;
  logic [5:0]                          obs_second;
  logic [5:0]                          true_first;
  logic [5:0]                          true_second;
  logic                                obs_missing;
  logic                                last;

  modport source (output valid, mode, locus, entry_index, table_value, category, obs_first,
                  obs_second, true_first, true_second, obs_missing, last, input ready);
  modport sink (input valid, mode, locus, entry_index, table_value, category, obs_first,
                obs_second, true_first, true_second, obs_missing, last, output ready);
endinterface

// File: rtl/core/gela_out_if.sv
// Interface: result item channel of the log-likelihood accumulator.
`timescale 1ns / 1ps
interface gela_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gela_pkg::SUM_W-1:0]  log_likelihood;
  logic                               saturated;

  modport source (output valid, log_likelihood, saturated, input ready);
  modport sink (input valid, log_likelihood, saturated, output ready);
endinterface

// File: rtl/core/genotype_error_loglik_accumulator.sv
// Top level: table storage, sequencer and shared multiplier of the log-likelihood accumulator.
// Usage:
//   item_i carries write items (error term, allele frequency) and score items; result_o
//   carries the Q16.24 sum and the saturation flag after an item with last set.
//   cfg_we_i/cfg_wdata_i set the likelihood model; write it only while the block is idle.
// Sequencing:
//   A write item or a skipped score item completes in the idle state; a model 1/2 score item
//   reads and accumulates its error term; an item with last set then adds the emit state.
//   A model 0 item with a zero product goes straight to accumulation. A model 0 mismatch
//   takes a one-bit-per-cycle normalize and 24 squarings through the shared multiplier.
//   A model 0 match adds the exponential: range reduction by ln 2, eleven Taylor terms
//   (one-bit-per-cycle divider), and a second logarithm.
//   item_i.ready is high only while the sequencer is idle; one item is in work at a time.
// Reset:
//   Clears the sum, the flag, the model register and the output valid. The tables keep no
//   reset value and must be written before they are scored against.
// Stall:
//   A result waits in the output register; the next items are taken meanwhile, and a
//   second result holds the sequencer until the first is taken.
`timescale 1ns / 1ps
module genotype_error_loglik_accumulator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  gela_in_if.sink           item_i,
  gela_out_if.source        result_o
);

  gela_pkg::gela_state_e state_q, state_d;

  logic [1:0]  model_q;
  logic [gela_pkg::LOCUS_W-1:0] locus_q;
  logic [1:0]  cat_q;
  logic [5:0]  o1_q, o2_q, t1_q, t2_q;
  logic        last_q;
  logic [gela_pkg::COL_W-1:0] col_q;

  logic [gela_pkg::FREQ_W-1:0] f1_q, frd_q;
  logic signed [31:0] e0_q, e1_q, erd_q;
  logic signed [65:0] prod_q;
  logic [33:0] x_q;
  logic [5:0]  k_q;
  logic [30:0] mant_q;
  logic [23:0] frac_q;
  logic [4:0]  cnt_q;
  logic        ln_sel_q;
  logic signed [33:0] a_q, hi_q;
  logic [28:0] d_q;
  logic [5:0]  n_q;
  logic [31:0] r32_q, term_q, dq_q;
  logic [32:0] tsum_q;
  logic [3:0]  tk_q, rem_q;
  logic signed [35:0] t_q;
  logic signed [39:0] sum_q;
  logic        ovf_q;
  logic        out_valid_q, out_sat_q;
  logic signed [39:0] out_ll_q;

  logic [31:0] err_mem [gela_pkg::ERR_DEPTH];
  logic [gela_pkg::FREQ_W-1:0] frq_mem [gela_pkg::FRQ_DEPTH];

  logic        accept, out_load;
  logic [gela_pkg::LOCUS_W+gela_pkg::COL_W-1:0]     err_raddr;
  logic [gela_pkg::LOCUS_W+gela_pkg::ALLELE_W-1:0]  frq_raddr;
  logic signed [32:0] mul_a, mul_b;
  logic [8:0]  snp_in;
  logic        snp_ok;
  logic        match;
  logic [32:0] p_val;
  logic signed [31:0] ln_val;
  logic signed [33:0] lp_sum, e0_x, e1_x, hi_c, lo_c;
  logic signed [34:0] diff;
  logic [7:0]  kdiff;
  logic [31:0] log2_val;
  logic [31:0] m2;
  logic [4:0]  rs;
  logic        div_ge;
  logic [32:0] y_val;
  logic signed [40:0] acc_s;

  assign accept = item_i.valid && item_i.ready;
  assign snp_in = gela_pkg::snp_col(item_i.obs_first, item_i.true_first, item_i.category);
  assign snp_ok = (snp_in[8:gela_pkg::COL_W] == '0);

  assign match  = (o1_q == t1_q && o2_q == t2_q) || (o2_q == t1_q && o1_q == t2_q);
  assign p_val  = (o1_q == o2_q) ? {1'b0, prod_q[31:0]} : {prod_q[31:0], 1'b0};
  assign ln_val = prod_q[55:24];
  assign e0_x   = {{2{e0_q[31]}}, e0_q};
  assign e1_x   = {{2{e1_q[31]}}, e1_q};
  assign lp_sum = {{2{ln_val[31]}}, ln_val} + e1_x;
  assign hi_c   = (a_q > e0_x) ? a_q : e0_x;
  assign lo_c   = (a_q > e0_x) ? e0_x : a_q;
  assign diff   = {hi_c[33], hi_c} - {lo_c[33], lo_c};
  assign kdiff  = {2'b0, k_q} - 8'd32;
  assign log2_val = {kdiff, frac_q};
  assign m2     = prod_q[61:30];
  assign rs     = {rem_q, dq_q[31]};
  assign div_ge = (rs >= {1'b0, tk_q});
  assign y_val  = tsum_q >> n_q;
  assign acc_s  = {sum_q[39], sum_q} + {{5{t_q[35]}}, t_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      gela_pkg::S_IDLE: begin
        if (accept) begin
          state_d = item_i.last ? gela_pkg::S_EMIT : gela_pkg::S_IDLE;
          if (item_i.mode == gela_pkg::MODE_SCORE && !item_i.obs_missing) begin
            case (model_q)
              gela_pkg::MODEL_MIX:   state_d = gela_pkg::S_RD_A;
              gela_pkg::MODEL_SNP:   if (snp_ok) state_d = gela_pkg::S_RD_E;
              gela_pkg::MODEL_CLASS: state_d = gela_pkg::S_RD_E;
              default: ;
            endcase
          end
        end
      end
      gela_pkg::S_RD_A: state_d = gela_pkg::S_RD_B;
      gela_pkg::S_RD_B: state_d = gela_pkg::S_MULP;
      gela_pkg::S_MULP: state_d = gela_pkg::S_PROD;
      gela_pkg::S_PROD: state_d = (p_val == '0) ? gela_pkg::S_ACC : gela_pkg::S_LN_NORM;
      gela_pkg::S_LN_NORM: if (x_q[33]) state_d = gela_pkg::S_LN_SQ;
      gela_pkg::S_LN_SQ: state_d = gela_pkg::S_LN_CHK;
      gela_pkg::S_LN_CHK: state_d = (cnt_q == '0) ? gela_pkg::S_LN_MUL : gela_pkg::S_LN_SQ;
      gela_pkg::S_LN_MUL: state_d = gela_pkg::S_LN_END;
      gela_pkg::S_LN_END:
        state_d = (!ln_sel_q && match) ? gela_pkg::S_LSE : gela_pkg::S_ACC;
      gela_pkg::S_LSE:
        state_d = (diff >= 35'(gela_pkg::EXP_LIMIT)) ? gela_pkg::S_LN_NORM
                                                     : gela_pkg::S_EXP_RED;
      gela_pkg::S_EXP_RED:
        if (d_q < 29'(gela_pkg::LN2_Q24)) state_d = gela_pkg::S_TAY_MUL;
      gela_pkg::S_TAY_MUL: state_d = gela_pkg::S_TAY_LD;
      gela_pkg::S_TAY_LD:  state_d = gela_pkg::S_TAY_DIV;
      gela_pkg::S_TAY_DIV: if (cnt_q == '0) state_d = gela_pkg::S_TAY_ADD;
      gela_pkg::S_TAY_ADD:
        state_d = (tk_q == gela_pkg::TAY_LAST) ? gela_pkg::S_EXP_END : gela_pkg::S_TAY_MUL;
      gela_pkg::S_EXP_END: state_d = gela_pkg::S_LN_NORM;
      gela_pkg::S_RD_E:  state_d = gela_pkg::S_GET_E;
      gela_pkg::S_GET_E: state_d = gela_pkg::S_ACC;
      gela_pkg::S_ACC:   state_d = last_q ? gela_pkg::S_EMIT : gela_pkg::S_IDLE;
      gela_pkg::S_EMIT:  if (out_load) state_d = gela_pkg::S_IDLE;
      default: state_d = gela_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready = (state_q == gela_pkg::S_IDLE);
    out_load  = (state_q == gela_pkg::S_EMIT) && (!out_valid_q || result_o.ready);
    err_raddr = {locus_q, col_q};
    frq_raddr = {locus_q, o2_q};
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      gela_pkg::S_RD_A: begin
        err_raddr = {locus_q, {(gela_pkg::COL_W-2){1'b0}}, cat_q};
        frq_raddr = {locus_q, o1_q};
      end
      gela_pkg::S_RD_B: begin
        err_raddr = {locus_q, {(gela_pkg::COL_W-2){1'b0}}, cat_q}
                  + {{(gela_pkg::LOCUS_W+gela_pkg::COL_W-1){1'b0}}, 1'b1};
      end
      gela_pkg::S_MULP: begin
        mul_a = {17'b0, f1_q};
        mul_b = {17'b0, (o1_q == o2_q) ? f1_q : frd_q};
      end
      gela_pkg::S_LN_SQ: begin
        mul_a = {2'b0, mant_q};
        mul_b = {2'b0, mant_q};
      end
      gela_pkg::S_LN_MUL: begin
        mul_a = {log2_val[31], log2_val};
        mul_b = {9'b0, gela_pkg::LN2_Q24};
      end
      gela_pkg::S_TAY_MUL: begin
        mul_a = {1'b0, term_q};
        mul_b = {1'b0, r32_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.mode == gela_pkg::MODE_ERR && item_i.entry_index[5] == 1'b0) begin
      err_mem[{item_i.locus, item_i.entry_index[gela_pkg::COL_W-1:0]}] <= item_i.table_value;
    end
    erd_q <= err_mem[err_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.mode == gela_pkg::MODE_FREQ) begin
      frq_mem[{item_i.locus, item_i.entry_index}] <= item_i.table_value[gela_pkg::FREQ_W-1:0];
    end
    frd_q <= frq_mem[frq_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gela_pkg::S_IDLE;
      model_q     <= gela_pkg::MODEL_MIX;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) model_q <= cfg_wdata_i;
      if (state_q == gela_pkg::S_ACC) begin
        if (acc_s > gela_pkg::SUM_MAX) begin
          sum_q <= gela_pkg::SUM_MAX[39:0];
          ovf_q <= 1'b1;
        end else if (acc_s < gela_pkg::SUM_MIN) begin
          sum_q <= gela_pkg::SUM_MIN[39:0];
          ovf_q <= 1'b1;
        end else begin
          sum_q <= acc_s[39:0];
        end
      end
      if (out_load) begin
        sum_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({{33{mul_a[32]}}, mul_a}) * $signed({{33{mul_b[32]}}, mul_b});
    if (out_load) begin
      out_ll_q  <= sum_q;
      out_sat_q <= ovf_q;
    end
    case (state_q)
      gela_pkg::S_IDLE: begin
        if (accept) begin
          locus_q <= item_i.locus;
          cat_q   <= item_i.category;
          o1_q    <= item_i.obs_first;
          o2_q    <= item_i.obs_second;
          t1_q    <= item_i.true_first;
          t2_q    <= item_i.true_second;
          last_q  <= item_i.last;
          col_q   <= (model_q == gela_pkg::MODEL_SNP) ? snp_in[gela_pkg::COL_W-1:0]
                   : gela_pkg::class_col(item_i.obs_first, item_i.obs_second,
                                         item_i.true_first, item_i.true_second,
                                         item_i.category);
        end
      end
      gela_pkg::S_RD_B: begin
        e0_q <= erd_q;
        f1_q <= frd_q;
      end
      gela_pkg::S_MULP: e1_q <= erd_q;
      gela_pkg::S_PROD: begin
        ln_sel_q <= 1'b0;
        x_q      <= {1'b0, p_val};
        k_q      <= 6'd33;
        if (match) t_q <= {{4{e0_q[31]}}, e0_q};
        else t_q <= {{4{gela_pkg::LN_FLOOR[31]}}, gela_pkg::LN_FLOOR} + {{2{e1_x[33]}}, e1_x};
      end
      gela_pkg::S_LN_NORM: begin
        if (x_q[33]) begin
          mant_q <= x_q[33:3];
          frac_q <= '0;
          cnt_q  <= 5'd23;
        end else begin
          x_q <= {x_q[32:0], 1'b0};
          k_q <= k_q - 6'd1;
        end
      end
      gela_pkg::S_LN_CHK: begin
        if (m2[31]) begin
          mant_q        <= m2[31:1];
          frac_q[cnt_q] <= 1'b1;
        end else begin
          mant_q <= m2[30:0];
        end
        cnt_q <= cnt_q - 5'd1;
      end
      gela_pkg::S_LN_END: begin
        if (ln_sel_q) begin
          t_q <= {{2{hi_q[33]}}, hi_q} + {{4{ln_val[31]}}, ln_val};
        end else begin
          a_q <= lp_sum;
          t_q <= {{2{lp_sum[33]}}, lp_sum};
        end
      end
      gela_pkg::S_LSE: begin
        hi_q     <= hi_c;
        d_q      <= diff[28:0];
        n_q      <= '0;
        ln_sel_q <= 1'b1;
        x_q      <= {1'b0, gela_pkg::ONE_Q32};
        k_q      <= 6'd33;
      end
      gela_pkg::S_EXP_RED: begin
        if (d_q >= 29'(gela_pkg::LN2_Q24)) begin
          d_q <= d_q - 29'(gela_pkg::LN2_Q24);
          n_q <= n_q + 6'd1;
        end else begin
          r32_q  <= {d_q[23:0], 8'b0};
          term_q <= {d_q[23:0], 8'b0};
          tsum_q <= gela_pkg::ONE_Q32 - {1'b0, d_q[23:0], 8'b0};
          tk_q   <= 4'd2;
        end
      end
      gela_pkg::S_TAY_LD: begin
        dq_q  <= prod_q[63:32];
        rem_q <= '0;
        cnt_q <= 5'd31;
      end
      gela_pkg::S_TAY_DIV: begin
        rem_q <= div_ge ? 4'(rs - {1'b0, tk_q}) : rs[3:0];
        dq_q  <= {dq_q[30:0], div_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      gela_pkg::S_TAY_ADD: begin
        term_q <= dq_q;
        tsum_q <= tk_q[0] ? tsum_q - {1'b0, dq_q} : tsum_q + {1'b0, dq_q};
        tk_q   <= tk_q + 4'd1;
      end
      gela_pkg::S_EXP_END: begin
        x_q <= {1'b0, gela_pkg::ONE_Q32} + {1'b0, y_val};
        k_q <= 6'd33;
      end
      gela_pkg::S_GET_E: t_q <= {{4{erd_q[31]}}, erd_q};
      default: ;
    endcase
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.log_likelihood = out_ll_q;
  assign result_o.saturated      = out_sat_q;

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gela_pkg::S_LN_SQ |-> mant_q[30])
    else $error("mantissa not normalized before squaring");

  a_tsum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gela_pkg::S_TAY_MUL |-> tsum_q <= gela_pkg::ONE_Q32)
    else $error("Taylor sum out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gela_pkg::S_TAY_DIV |-> rem_q < tk_q)
    else $error("divider remainder not below divisor");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_q == '0 && !ovf_q && out_valid_q))
    else $error("sum not cleared after emit");

endmodule
